// ----- design/rtx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtx_pkg
// Shared types, codes and kernel builder for the retinex ratio block.
// ----------------------------------------------------------------------------
package rtx_pkg;

	localparam logic [63:0] QONE = 64'd1 << 30;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int GAIN_W     = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;
	localparam logic [GAIN_W-1:0]     RST_OUTPUT_GAIN  = 10'd170;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [7:0] SAT_VALUE = 8'd255;

	// kernel table holds up to 8x8 quadrant weights of 16 bits
	localparam int KTAB_W = 1024;
	localparam int KIDX_W = 6;
	localparam int ACC_W  = 32;
	localparam int NUM_W  = 32;
	localparam int GNUM_W = NUM_W + GAIN_W;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_FLUSH,
		BK_MUL1,
		BK_MUL2,
		BK_SAT,
		BK_DIV,
		BK_DONE
	} bk_state_t;

	function automatic logic [63:0] kern_e1(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = QONE;
		pos  = QONE;
		neg  = '0;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * x) >> 30) / 64'(k);
			if (k[0]) neg = neg + term;
			else pos = pos + term;
		end
		return pos - neg;
	endfunction

	function automatic logic [15:0] kern_weight(input logic [63:0] e1, input int d2);
		logic [63:0] p;
		p = QONE;
		for (int d = 0; d < d2; d++) p = (p * e1) >> 30;
		return 16'((p * 64'd65535 + (QONE >> 1)) >> 30);
	endfunction

	function automatic logic [KTAB_W-1:0] kern_table(input logic [63:0] e1, input int radius);
		logic [KTAB_W-1:0] t;
		t = '0;
		for (int a = 0; a <= radius; a++)
			for (int b = 0; b <= radius; b++)
				t[(a * (radius + 1) + b) * 16 +: 16] = kern_weight(e1, a * a + b * b);
		return t;
	endfunction

	function automatic logic [ACC_W-1:0] kern_sum(input logic [KTAB_W-1:0] t, input int radius);
		logic [ACC_W-1:0] s;
		int aa;
		int bb;
		s = '0;
		for (int a = -radius; a <= radius; a++)
			for (int b = -radius; b <= radius; b++) begin
				aa = (a < 0) ? -a : a;
				bb = (b < 0) ? -b : b;
				s = s + ACC_W'(t[(aa * (radius + 1) + bb) * 16 +: 16]);
			end
		return s;
	endfunction

endpackage

// ----- design/rtx_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtx_fifo
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module rtx_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("request popped from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
		else $error("queue count did not follow push");

endmodule

// ----- design/rtx_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtx_front
// Accepts pixels and drains, writes the frame store, tracks positions and
// queues one request per result owed.
// ----------------------------------------------------------------------------
module rtx_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int RADIUS     = 5,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int JW = RW + CW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           command,
	input  logic [7:0]     red,
	input  logic [7:0]     green,
	input  logic [7:0]     blue,
	input  logic [WW-1:0]  eff_w,
	input  logic [HW-1:0]  eff_h,
	input  logic           all_idle,
	input  logic           fifo_full,
	output logic           push,
	output logic [JW-1:0]  job,
	output logic           wr_en,
	output logic [RW+CW-1:0] wr_addr,
	output logic [7:0]     wr_data
);

	localparam int QW = RW + WW + 1;
	localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;

	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;
	logic [PW-1:0] pend_q;

	logic          accept;
	logic          at_origin;
	logic [7:0]    pix_v;
	logic [QW-1:0] qi;
	logic [QW-1:0] thr;
	logic          emit_px;
	logic          emit_dr;
	logic          last;
	logic          in_col_wrap;
	logic          in_row_wrap;
	logic          out_col_wrap;
	logic          out_row_wrap;

	always_comb begin
		at_origin = (in_row_q == '0) && (in_col_q == '0);
		in_stall  = fifo_full || (at_origin && !all_idle);
		accept    = in_valid && !in_stall;

		pix_v = red;
		if (green > pix_v) pix_v = green;
		if (blue > pix_v) pix_v = blue;

		qi  = QW'(in_row_q) * QW'(eff_w) + QW'(in_col_q);
		thr = QW'(RADIUS) * QW'(eff_w) + QW'(RADIUS);

		emit_px = (command == rtx_pkg::CMD_PIXEL) && (qi >= thr);
		emit_dr = (command == rtx_pkg::CMD_DRAIN) && at_origin && (pend_q != '0);
		push    = accept && (emit_px || emit_dr);

		last = (32'(out_row_q) == 32'(eff_h) - 32'd1) &&
			(32'(out_col_q) == 32'(eff_w) - 32'd1);
		job  = {out_row_q, out_col_q, last};

		wr_en   = accept && (command == rtx_pkg::CMD_PIXEL);
		wr_addr = {in_row_q, in_col_q};
		wr_data = pix_v;

		in_col_wrap  = (32'(in_col_q) + 32'd1) >= 32'(eff_w);
		in_row_wrap  = (32'(in_row_q) + 32'd1) >= 32'(eff_h);
		out_col_wrap = (32'(out_col_q) + 32'd1) >= 32'(eff_w);
		out_row_wrap = (32'(out_row_q) + 32'd1) >= 32'(eff_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			if (command == rtx_pkg::CMD_PIXEL) begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_wrap ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (at_origin) begin
					out_row_q <= '0;
					out_col_q <= '0;
					pend_q    <= PW'(1);
				end else if (!emit_px) begin
					pend_q <= pend_q + 1'b1;
				end
			end else if (emit_dr) begin
				pend_q <= pend_q - 1'b1;
			end
			if (push) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/rtx_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtx_back
// Frame store, weighted window sum, ratio divider and output register.
// ----------------------------------------------------------------------------
module rtx_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int RADIUS     = 5,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int JW = RW + CW + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [WW-1:0]             eff_w,
	input  logic [HW-1:0]             eff_h,
	input  logic [rtx_pkg::GAIN_W-1:0] gain,
	input  logic                      fifo_empty,
	output logic                      pop,
	input  logic [JW-1:0]             job,
	input  logic                      wr_en,
	input  logic [RW+CW-1:0]          wr_addr,
	input  logic [7:0]                wr_data,
	output logic                      idle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                enhanced_value,
	output logic                      in_band,
	output logic                      zero_blur,
	output logic                      frame_last
);

	localparam int AW    = RW + CW;
	localparam int KSIDE = RADIUS + 1;
	localparam int SPAN  = 2 * RADIUS + 1;
	localparam int KB    = $clog2(SPAN);
	localparam int ACC_W = rtx_pkg::ACC_W;
	localparam int NUM_W = rtx_pkg::NUM_W;
	localparam int GW    = rtx_pkg::GNUM_W;
	localparam logic [63:0] KX = rtx_pkg::QONE / 64'(RADIUS * RADIUS);
	localparam logic [63:0] E1 = rtx_pkg::kern_e1(KX);
	localparam logic [rtx_pkg::KTAB_W-1:0] KTAB = rtx_pkg::kern_table(E1, RADIUS);
	localparam logic [ACC_W-1:0] WSUM = rtx_pkg::kern_sum(KTAB, RADIUS);

	logic [7:0] mem [2**AW];

	rtx_pkg::bk_state_t state_q, state_nx;

	logic [RW-1:0]    job_row_q;
	logic [CW-1:0]    job_col_q;
	logic             job_last_q;
	logic [KB-1:0]    iy_q;
	logic [KB-1:0]    ix_q;
	logic [7:0]       rdata_s1;
	logic [15:0]      wt_s1;
	logic             vld_s1;
	logic             ctr_s1;
	logic [23:0]      prod_s2;
	logic             vld_s2;
	logic [ACC_W-1:0] acc_q;
	logic [7:0]       v_q;
	logic [NUM_W-1:0] num_q;
	logic [GW-1:0]    rem_q;
	logic             band_q;
	logic             sat_q;
	logic [7:0]       quo_q;
	logic [2:0]       bit_q;
	logic             ov_q;
	logic [7:0]       ev_q;
	logic             ib_q;
	logic             zb_q;
	logic             fl_q;

	logic [AW-1:0]            rd_addr;
	logic [15:0]              wt;
	logic                     last_tap;
	logic                     center;
	logic                     out_free;
	logic                     load;
	logic [rtx_pkg::KIDX_W-1:0] widx;
	logic [GW-1:0]            dshift;
	logic                     blur_zero;

	always_comb begin
		int r;
		int c;
		int y;
		int x;
		int ay;
		int ax;
		r = int'(job_row_q);
		if (r > int'(eff_h) - 1) r = int'(eff_h) - 1;
		c = int'(job_col_q);
		if (c > int'(eff_w) - 1) c = int'(eff_w) - 1;
		y = r + int'(iy_q) - RADIUS;
		if (y < 0) y = 0;
		else if (y > int'(eff_h) - 1) y = int'(eff_h) - 1;
		x = c + int'(ix_q) - RADIUS;
		if (x < 0) x = 0;
		else if (x > int'(eff_w) - 1) x = int'(eff_w) - 1;
		rd_addr = {y[RW-1:0], x[CW-1:0]};
		ay = int'(iy_q) - RADIUS;
		if (ay < 0) ay = -ay;
		ax = int'(ix_q) - RADIUS;
		if (ax < 0) ax = -ax;
		widx = rtx_pkg::KIDX_W'(ay * KSIDE + ax);
		wt   = KTAB[{widx, 4'b0000} +: 16];
	end

	assign last_tap  = (iy_q == KB'(2 * RADIUS)) && (ix_q == KB'(2 * RADIUS));
	assign center    = (iy_q == KB'(RADIUS)) && (ix_q == KB'(RADIUS));
	assign out_free  = !ov_q || !out_stall;
	assign idle      = (state_q == rtx_pkg::BK_IDLE);
	assign dshift    = GW'(acc_q) << bit_q;
	assign blur_zero = (acc_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rtx_pkg::BK_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		load     = 1'b0;
		case (state_q)
			rtx_pkg::BK_IDLE: begin
				if (!fifo_empty) begin
					pop      = 1'b1;
					state_nx = rtx_pkg::BK_SUM;
				end
			end
			rtx_pkg::BK_SUM: begin
				if (last_tap) state_nx = rtx_pkg::BK_FLUSH;
			end
			rtx_pkg::BK_FLUSH: begin
				if (!vld_s1 && !vld_s2) state_nx = rtx_pkg::BK_MUL1;
			end
			rtx_pkg::BK_MUL1: begin
				state_nx = rtx_pkg::BK_MUL2;
			end
			rtx_pkg::BK_MUL2: begin
				state_nx = blur_zero ? rtx_pkg::BK_DONE : rtx_pkg::BK_SAT;
			end
			rtx_pkg::BK_SAT: begin
				state_nx = rtx_pkg::BK_DIV;
			end
			rtx_pkg::BK_DIV: begin
				if (bit_q == '0) state_nx = rtx_pkg::BK_DONE;
			end
			rtx_pkg::BK_DONE: begin
				if (out_free) begin
					load     = 1'b1;
					state_nx = rtx_pkg::BK_IDLE;
				end
			end
			default: state_nx = rtx_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iy_q   <= '0;
			ix_q   <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == rtx_pkg::BK_SUM);
			vld_s2 <= vld_s1;
			if (pop) begin
				iy_q <= '0;
				ix_q <= '0;
			end else if (state_q == rtx_pkg::BK_SUM) begin
				if (ix_q == KB'(2 * RADIUS)) begin
					ix_q <= '0;
					iy_q <= iy_q + 1'b1;
				end else begin
					ix_q <= ix_q + 1'b1;
				end
			end
			if (load) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			{job_row_q, job_col_q, job_last_q} <= job;
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		wt_s1  <= wt;
		ctr_s1 <= center;
		prod_s2 <= 24'(rdata_s1) * 24'(wt_s1);
		if (vld_s1 && ctr_s1) v_q <= rdata_s1;
		case (state_q)
			rtx_pkg::BK_MUL1: begin
				num_q <= NUM_W'(v_q) * WSUM;
			end
			rtx_pkg::BK_MUL2: begin
				rem_q  <= GW'(gain) * GW'(num_q);
				band_q <= ((36'(num_q) * 36'd10) > 36'(acc_q)) &&
					(36'(num_q) < (36'(acc_q) * 36'd10));
			end
			rtx_pkg::BK_SAT: begin
				sat_q <= rem_q >= (GW'(acc_q) << 8);
				bit_q <= 3'd7;
				quo_q <= '0;
			end
			rtx_pkg::BK_DIV: begin
				if (rem_q >= dshift) begin
					rem_q        <= rem_q - dshift;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			zb_q <= blur_zero;
			fl_q <= job_last_q;
			ib_q <= blur_zero ? 1'b0 : band_q;
			ev_q <= blur_zero ? 8'd0 : (sat_q ? rtx_pkg::SAT_VALUE : quo_q);
		end
	end

	assign out_valid      = ov_q;
	assign enhanced_value = ev_q;
	assign in_band        = ib_q;
	assign zero_blur      = zb_q;
	assign frame_last     = fl_q;

endmodule

// ----- design/single_scale_retinex_ratio_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_scale_retinex_ratio_top
// Value-channel retinex ratio over a Gaussian window, raster pixel stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command plus RGB. Pixels are written
// to a full frame store; a pixel past RADIUS rows and RADIUS columns queues
// a request for the output position, and drains at the frame origin queue
// the requests still owed after the last pixel.
// Output channel (out_valid/out_stall): one result per request, registered.
// Configuration (cfg_valid/cfg_ready): always ready; it is to be written
// only while idle, which the block itself does not enforce. A request in
// the back makes one store read per window tap on the single read port,
// then two multiplies and an 8-step divider. A two-entry queue lets the
// front run ahead meanwhile.
// A pixel at the frame origin waits until all requests are finished.
// When out_stall is high the result register holds and the back waits;
// the front keeps taking items until the queue fills.
// Reset clears positions and counters and loads config (640, 480, 170); the frame
// store is not cleared.
// ----------------------------------------------------------------------------
module single_scale_retinex_ratio_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int RADIUS     = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     enhanced_value,
	output logic                           in_band,
	output logic                           zero_blur,
	output logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rtx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtx_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int JW = RW + CW + 1;

	logic [rtx_pkg::CFG_DATA_W-1:0] frame_width_q;
	logic [rtx_pkg::CFG_DATA_W-1:0] frame_height_q;
	logic [rtx_pkg::GAIN_W-1:0]     output_gain_q;
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	logic          push;
	logic          pop;
	logic [JW-1:0] job_in;
	logic [JW-1:0] job_out;
	logic          fifo_empty;
	logic          fifo_full;
	logic          back_idle;
	logic          wr_en;
	logic [RW+CW-1:0] wr_addr;
	logic [7:0]    wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rtx_pkg::RST_FRAME_WIDTH;
			frame_height_q <= rtx_pkg::RST_FRAME_HEIGHT;
			output_gain_q  <= rtx_pkg::RST_OUTPUT_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rtx_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				rtx_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				rtx_pkg::CFG_OUTPUT_GAIN:  output_gain_q  <= cfg_data[rtx_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) eff_w = WW'(1);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		else eff_w = WW'(frame_width_q);
		if (frame_height_q == '0) eff_h = HW'(1);
		else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
		else eff_h = HW'(frame_height_q);
	end

	rtx_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.RADIUS    (RADIUS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.all_idle (back_idle && fifo_empty),
		.fifo_full(fifo_full),
		.push     (push),
		.job      (job_in),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	rtx_fifo #(
		.W(JW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.pop   (pop),
		.rdata (job_out),
		.empty (fifo_empty),
		.full  (fifo_full)
	);

	rtx_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.RADIUS    (RADIUS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.eff_w         (eff_w),
		.eff_h         (eff_h),
		.gain          (output_gain_q),
		.fifo_empty    (fifo_empty),
		.pop           (pop),
		.job           (job_out),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.idle          (back_idle),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.enhanced_value(enhanced_value),
		.in_band       (in_band),
		.zero_blur     (zero_blur),
		.frame_last    (frame_last)
	);

endmodule
